// File: design/assert_macros.svh
// Shared assertion forms for the circle rasterizer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on the rising clock, off during reset.
`define MCR_ASSERT_IMP(lbl, clk, rst, pre, post) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("%m: assertion failed");

// Next-cycle implication, checked on the rising clock, off during reset.
`define MCR_ASSERT_NXT(lbl, clk, rst, pre, post) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("%m: assertion failed");

`endif

// File: design/mcr_pkg.sv
`default_nettype none
package mcr_pkg;

   localparam int unsigned COORD_W  = 12;
   localparam int unsigned RAD_W    = 7;
   localparam int unsigned COLOUR_W = 32;
   localparam int unsigned ADDR_W   = 23;
   localparam int unsigned STRIDE_W = 13;
   localparam int unsigned ERR_W    = 10;
   localparam int unsigned NUM_PTS  = 8;

   localparam logic [RAD_W-1:0]    MAX_RADIUS = 7'd85;
   localparam logic [STRIDE_W-1:0] MAX_STRIDE = 13'd4096;

   // register map, word index = paddr[3:2]
   typedef enum logic [1:0] {
      REG_WIDTH  = 2'd0,
      REG_HEIGHT = 2'd1,
      REG_STRIDE = 2'd2
   } reg_index_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MUL_CY,
      ST_MUL_R,
      ST_RUN
   } seq_state_type;

   typedef struct packed {
      logic accept;   // capture command
      logic mul_cy;   // multiplier: center_y * stride
      logic mul_r;    // multiplier: radius * stride
      logic emit;     // one loop iteration into the output register
   } seq_ctrl_type;

   typedef struct packed {
      logic out_free;   // output register can take a word
      logic step_last;  // current iteration ends the circle
   } dp_status_type;

   typedef struct packed {
      logic [COORD_W-1:0]  width;
      logic [COORD_W-1:0]  height;
      logic [STRIDE_W-1:0] stride;  // already saturated
   } cfg_type;

endpackage
`default_nettype wire

// File: design/mcr_csr.sv
`default_nettype none
module mcr_csr
   import mcr_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [3:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready,
   output cfg_type          cfg
);

   logic [COORD_W-1:0]  width_ff, width_in;
   logic [COORD_W-1:0]  height_ff, height_in;
   logic [STRIDE_W-1:0] stride_ff, stride_in;
   logic                wr_en;
   reg_index_type       idx;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;
   assign idx        = reg_index_type'(csr_paddr[3:2]);

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      stride_in = stride_ff;
      if (wr_en) begin
         case (idx)
            REG_WIDTH:  width_in  = csr_pwdata[COORD_W-1:0];
            REG_HEIGHT: height_in = csr_pwdata[COORD_W-1:0];
            REG_STRIDE: stride_in = csr_pwdata[STRIDE_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= 12'd640;
         height_ff <= 12'd480;
         stride_ff <= 13'd640;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         stride_ff <= stride_in;
      end
   end

   always_comb begin
      case (idx)
         REG_WIDTH:  csr_prdata = {20'd0, width_ff};
         REG_HEIGHT: csr_prdata = {20'd0, height_ff};
         REG_STRIDE: csr_prdata = {19'd0, stride_ff};
         default:    csr_prdata = 32'd0;
      endcase
   end

   assign cfg.width  = width_ff;
   assign cfg.height = height_ff;
   assign cfg.stride = (stride_ff > MAX_STRIDE) ? MAX_STRIDE : stride_ff;

endmodule
`default_nettype wire

// File: design/mcr_seq.sv
`default_nettype none
`include "assert_macros.svh"
module mcr_seq
   import mcr_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_tvalid,
   input  wire dp_status_type sts,
   output logic               req_tready,
   output seq_ctrl_type       ctrl
);

   seq_state_type st_ff, st_in;

   always_comb begin
      st_in = st_ff;
      case (st_ff)
         ST_IDLE:   if (req_tvalid) st_in = ST_MUL_CY;
         ST_MUL_CY: st_in = ST_MUL_R;
         ST_MUL_R:  st_in = ST_RUN;
         ST_RUN:    if (sts.out_free && sts.step_last) st_in = ST_IDLE;
         default:   st_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_IDLE;
      end else begin
         st_ff <= st_in;
      end
   end

   always_comb begin
      req_tready  = 1'b0;
      ctrl        = '0;
      case (st_ff)
         ST_IDLE: begin
            req_tready  = 1'b1;
            ctrl.accept = req_tvalid;
         end
         ST_MUL_CY: ctrl.mul_cy = 1'b1;
         ST_MUL_R:  ctrl.mul_r  = 1'b1;
         ST_RUN:    ctrl.emit   = sts.out_free;
         default: ;
      endcase
   end

   // the final iteration always returns the sequencer to idle
   `MCR_ASSERT_NXT(a_last_to_idle, clock, reset,
      (st_ff == ST_RUN) && sts.out_free && sts.step_last, st_ff == ST_IDLE)

endmodule
`default_nettype wire

// File: design/mcr_dp.sv
`default_nettype none
`include "assert_macros.svh"
module mcr_dp
   import mcr_pkg::*;
(
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire seq_ctrl_type                 ctrl,
   input  wire cfg_type                      cfg,
   input  wire logic signed [COORD_W-1:0]    req_center_x,
   input  wire logic signed [COORD_W-1:0]    req_center_y,
   input  wire logic [RAD_W-1:0]             req_radius,
   input  wire logic [COLOUR_W-1:0]          req_colour,
   input  wire logic                         rsp_tready,
   output dp_status_type                     sts,
   output logic                              rsp_valid,
   output logic [NUM_PTS*ADDR_W-1:0]         rsp_addrs,
   output logic [NUM_PTS-1:0]                rsp_mask,
   output logic [COLOUR_W-1:0]               rsp_colour,
   output logic                              rsp_last
);

   // command and loop state
   logic signed [COORD_W-1:0] cx_ff, cy_ff;
   logic [COLOUR_W-1:0]       col_ff;
   logic [RAD_W-1:0]          dx_ff, dx_in, dy_ff, dy_in;
   logic signed [ERR_W-1:0]   err_ff, err_in;
   // row offsets, kept modulo 2^ADDR_W
   logic [ADDR_W-1:0]         cys_ff, cys_in, dxs_ff, dxs_in, dys_ff, dys_in;

   // output register
   logic                      ov_ff, ov_in;
   logic [ADDR_W-1:0]         addr_ff [NUM_PTS];
   logic [NUM_PTS-1:0]        mask_ff;
   logic [COLOUR_W-1:0]       ocol_ff;
   logic                      olast_ff;

   logic [RAD_W-1:0]          r_cl;
   logic signed [12:0]        mul_a;
   logic signed [13:0]        mul_b;
   logic signed [26:0]        prod;
   logic [ADDR_W-1:0]         stride23;

   logic signed [13:0]        cx_e, cy_e, dx_e, dy_e;
   logic signed [13:0]        px [NUM_PTS];
   logic signed [13:0]        py [NUM_PTS];
   logic [ADDR_W-1:0]         base [NUM_PTS];
   logic [ADDR_W-1:0]         addr [NUM_PTS];
   logic [NUM_PTS-1:0]        on;

   logic                      err_neg;
   logic signed [8:0]         dy_n, dx_n;
   logic signed [10:0]        dy_w, dx_w, err_w, gain, err_n;

   assign r_cl     = (req_radius > MAX_RADIUS) ? MAX_RADIUS : req_radius;
   assign stride23 = {10'd0, cfg.stride};

   // shared multiplier: center row base, then radius row offset
   assign mul_a = ctrl.mul_r ? $signed({6'd0, dx_ff}) : $signed({cy_ff[COORD_W-1], cy_ff});
   assign mul_b = $signed({1'b0, cfg.stride});
   assign prod  = mul_a * mul_b;

   // eight symmetric points
   assign cx_e = {{2{cx_ff[COORD_W-1]}}, cx_ff};
   assign cy_e = {{2{cy_ff[COORD_W-1]}}, cy_ff};
   assign dx_e = $signed({7'd0, dx_ff});
   assign dy_e = $signed({7'd0, dy_ff});

   always_comb begin
      px[0] = cx_e + dx_e;  py[0] = cy_e + dy_e;  base[0] = cys_ff + dys_ff;
      px[1] = cx_e - dx_e;  py[1] = cy_e + dy_e;  base[1] = cys_ff + dys_ff;
      px[2] = cx_e + dx_e;  py[2] = cy_e - dy_e;  base[2] = cys_ff - dys_ff;
      px[3] = cx_e - dx_e;  py[3] = cy_e - dy_e;  base[3] = cys_ff - dys_ff;
      px[4] = cx_e + dy_e;  py[4] = cy_e + dx_e;  base[4] = cys_ff + dxs_ff;
      px[5] = cx_e - dy_e;  py[5] = cy_e + dx_e;  base[5] = cys_ff + dxs_ff;
      px[6] = cx_e + dy_e;  py[6] = cy_e - dx_e;  base[6] = cys_ff - dxs_ff;
      px[7] = cx_e - dy_e;  py[7] = cy_e - dx_e;  base[7] = cys_ff - dxs_ff;
      for (int i = 0; i < NUM_PTS; i++) begin
         on[i] = !px[i][13] && !py[i][13] &&
                 (px[i][12:0] < {1'b0, cfg.width}) &&
                 (py[i][12:0] < {1'b0, cfg.height});
         addr[i] = on[i] ? (base[i] + {10'd0, px[i][12:0]}) : '0;
      end
   end

   // midpoint step
   assign err_neg = err_ff[ERR_W-1];
   assign dy_n    = $signed({2'b00, dy_ff}) + 9'sd1;
   assign dx_n    = err_neg ? $signed({2'b00, dx_ff}) : $signed({2'b00, dx_ff}) - 9'sd1;
   assign dy_w    = {{2{dy_n[8]}}, dy_n};
   assign dx_w    = {{2{dx_n[8]}}, dx_n};
   assign err_w   = {err_ff[ERR_W-1], err_ff};
   assign gain    = err_neg ? ((dy_w <<< 1) + 11'sd1) : (((dy_w - dx_w) <<< 1) + 11'sd1);
   assign err_n   = err_w + gain;

   assign sts.step_last = dx_n < dy_n;
   assign sts.out_free  = !ov_ff || rsp_tready;

   always_comb begin
      dx_in  = dx_ff;
      dy_in  = dy_ff;
      err_in = err_ff;
      cys_in = cys_ff;
      dxs_in = dxs_ff;
      dys_in = dys_ff;
      if (ctrl.accept) begin
         dx_in  = r_cl;
         dy_in  = '0;
         err_in = 10'sd1 - $signed({3'd0, r_cl});
         dys_in = '0;
      end else if (ctrl.mul_cy) begin
         cys_in = prod[ADDR_W-1:0];
      end else if (ctrl.mul_r) begin
         dxs_in = prod[ADDR_W-1:0];
      end else if (ctrl.emit) begin
         dx_in  = dx_n[RAD_W-1:0];
         dy_in  = dy_n[RAD_W-1:0];
         err_in = err_n[ERR_W-1:0];
         dys_in = dys_ff + stride23;
         dxs_in = err_neg ? dxs_ff : (dxs_ff - stride23);
      end
   end

   always_comb begin
      ov_in = ov_ff;
      if (ctrl.emit) ov_in = 1'b1;
      else if (rsp_tready) ov_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dx_ff  <= '0;
         dy_ff  <= '0;
         err_ff <= '0;
         ov_ff  <= 1'b0;
      end else begin
         dx_ff  <= dx_in;
         dy_ff  <= dy_in;
         err_ff <= err_in;
         ov_ff  <= ov_in;
      end
   end

   always_ff @(posedge clock) begin
      cys_ff <= cys_in;
      dxs_ff <= dxs_in;
      dys_ff <= dys_in;
      if (ctrl.accept) begin
         cx_ff  <= req_center_x;
         cy_ff  <= req_center_y;
         col_ff <= req_colour;
      end
      if (ctrl.emit) begin
         for (int i = 0; i < NUM_PTS; i++) addr_ff[i] <= addr[i];
         mask_ff  <= on;
         ocol_ff  <= col_ff;
         olast_ff <= sts.step_last;
      end
   end

   always_comb begin
      for (int i = 0; i < NUM_PTS; i++) rsp_addrs[i*ADDR_W +: ADDR_W] = addr_ff[i];
   end

   assign rsp_valid  = ov_ff;
   assign rsp_mask   = mask_ff;
   assign rsp_colour = ocol_ff;
   assign rsp_last   = olast_ff;

   // incremental row offsets must track dy*stride and dx*stride
   `MCR_ASSERT_IMP(a_dys_track, clock, reset, ctrl.emit,
      dys_ff == (23'(dy_ff) * 23'(cfg.stride)))
   `MCR_ASSERT_IMP(a_dxs_track, clock, reset, ctrl.emit,
      dxs_ff == (23'(dx_ff) * 23'(cfg.stride)))

endmodule
`default_nettype wire

// File: design/midpoint_circle_rasterizer_unit.sv
// Midpoint circle rasterizer.
// req_ channel: one word per circle command (center, radius, colour).
// rsp_ channel: one word per loop iteration with eight symmetric pixel
//   addresses (y*stride + x), an on-screen mask, the colour, and tlast
//   on the final iteration. Addresses of clipped points read as zero.
// csr_ port: screen width, screen height, line stride at 0x0, 0x4, 0x8.
//   Write only while idle. Stride above 4096 is saturated.
// Flow: after a command word is taken, the sequencer runs the shared
//   multiplier in ST_MUL_CY (center row base), then ST_MUL_R (radius row
//   offset); then one result word per cycle unless rsp_tready stalls, about
//   radius/1.41 + 1 words, at most 64 (radius is clamped to 85).
//   req_tready is high only while the sequencer is idle.
// The output register decouples the sides: a rsp_tready stall freezes
//   the loop; the last word may still wait while the next command enters.
// Reset (synchronous): sequencer idle, output empty, registers back to
//   640 x 480 with stride 640.
`default_nettype none
module midpoint_circle_rasterizer_unit
   import mcr_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   // command: [11:0] center_x, [23:12] center_y, [30:24] radius, [62:31] colour
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [63:0]  req_tdata,
   // result: [183:0] addr_px_py..addr_my_mx (23 b each, low first),
   //         [191:184] onscreen_mask, [223:192] pixel_colour
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output logic [223:0]      rsp_tdata,
   output logic              rsp_tlast,
   // configuration
   input  wire logic         csr_psel,
   input  wire logic         csr_penable,
   input  wire logic         csr_pwrite,
   input  wire logic [3:0]   csr_paddr,
   input  wire logic [31:0]  csr_pwdata,
   output logic [31:0]       csr_prdata,
   output logic              csr_pready
);

   cfg_type                   cfg;
   seq_ctrl_type              ctrl;
   dp_status_type             sts;
   logic [NUM_PTS*ADDR_W-1:0] addrs;
   logic [NUM_PTS-1:0]        mask;
   logic [COLOUR_W-1:0]       colour;

   mcr_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   mcr_seq u_seq (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .sts        (sts),
      .req_tready (req_tready),
      .ctrl       (ctrl)
   );

   // tdata bit 63 is padding
   mcr_dp u_dp (
      .clock        (clock),
      .reset        (reset),
      .ctrl         (ctrl),
      .cfg          (cfg),
      .req_center_x ($signed(req_tdata[11:0])),
      .req_center_y ($signed(req_tdata[23:12])),
      .req_radius   (req_tdata[30:24]),
      .req_colour   (req_tdata[62:31]),
      .rsp_tready   (rsp_tready),
      .sts          (sts),
      .rsp_valid    (rsp_tvalid),
      .rsp_addrs    (addrs),
      .rsp_mask     (mask),
      .rsp_colour   (colour),
      .rsp_last     (rsp_tlast)
   );

   assign rsp_tdata = {colour, mask, addrs};

endmodule
`default_nettype wire
